>>> design/cci_pkg.sv
// ----------------------------------------------------------------------------
// cci_pkg: shared types and constants of the circle collision impulse unit
// Request and result structs, the sideband carried down the pipeline, and
// the lane map of the divider bank.
// ----------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

    localparam int WORD_W = 32;
    localparam int RAD_W  = 31;
    localparam int DIFF_W = 33;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int LANES  = 4;

    // divider bank lanes
    localparam int LANE_NX = 0;
    localparam int LANE_NY = 1;
    localparam int LANE_F1 = 2;
    localparam int LANE_F2 = 3;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [WORD_W-1:0] first_pos_x;
        logic signed [WORD_W-1:0] first_pos_y;
        logic signed [WORD_W-1:0] first_vel_x;
        logic signed [WORD_W-1:0] first_vel_y;
        logic        [RAD_W-1:0]  first_radius;
        logic        [RAD_W-1:0]  first_inv_mass;
        logic signed [WORD_W-1:0] second_pos_x;
        logic signed [WORD_W-1:0] second_pos_y;
        logic signed [WORD_W-1:0] second_vel_x;
        logic signed [WORD_W-1:0] second_vel_y;
        logic        [RAD_W-1:0]  second_radius;
        logic        [RAD_W-1:0]  second_inv_mass;
    } cci_pair_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_first_vel_x;
        logic signed [WORD_W-1:0] new_first_vel_y;
        logic signed [WORD_W-1:0] new_second_vel_x;
        logic signed [WORD_W-1:0] new_second_vel_y;
        logic                     impulse_applied;
    } cci_result_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] v1x;
        logic signed [WORD_W-1:0] v1y;
        logic signed [WORD_W-1:0] v2x;
        logic signed [WORD_W-1:0] v2y;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] rvx;
        logic signed [DIFF_W-1:0] rvy;
        logic        [RAD_W-1:0]  m1;
        logic        [RAD_W-1:0]  m2;
        logic        [WORD_W-1:0] msum;
        logic                     hit_ok;
    } cci_side_t;

endpackage

`default_nettype wire

>>> design/cci_prep.sv
// ----------------------------------------------------------------------------
// cci_prep: offsets, squares and overlap test
// Four stages: differences, magnitudes, squares, squared-distance sum and
// the exact overlap compare against the squared radius sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_prep (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid_in,
    input  cci_pkg::cci_pair_t        pair_in,
    output logic                      valid_out,
    output logic [cci_pkg::SQ_W-1:0]  dist_sq,
    output cci_pkg::cci_side_t        side_out
);
    import cci_pkg::*;

    cci_side_t         s1_next, s1_reg, s2_reg, s3_reg, s4_next, s4_reg;
    logic [WORD_W-1:0] rs_next, rs1_reg, rs2_reg;
    logic [DIFF_W-1:0] ax_next, ay_next;
    logic [WORD_W-1:0] ax_reg, ay_reg;
    logic              lt_next, lt2_reg, lt3_reg;
    logic [SQ_W-1:0]   dx2_reg, dy2_reg, rsq_reg;
    logic [SQ_W:0]     sum_next;
    logic [SQ_W-1:0]   dist_sq_reg;
    logic [3:0]        vld_reg;

    always_comb
    begin
        s1_next.v1x    = pair_in.first_vel_x;
        s1_next.v1y    = pair_in.first_vel_y;
        s1_next.v2x    = pair_in.second_vel_x;
        s1_next.v2y    = pair_in.second_vel_y;
        s1_next.dx     = DIFF_W'(pair_in.second_pos_x) - DIFF_W'(pair_in.first_pos_x);
        s1_next.dy     = DIFF_W'(pair_in.second_pos_y) - DIFF_W'(pair_in.first_pos_y);
        s1_next.rvx    = DIFF_W'(pair_in.second_vel_x) - DIFF_W'(pair_in.first_vel_x);
        s1_next.rvy    = DIFF_W'(pair_in.second_vel_y) - DIFF_W'(pair_in.first_vel_y);
        s1_next.m1     = pair_in.first_inv_mass;
        s1_next.m2     = pair_in.second_inv_mass;
        s1_next.msum   = WORD_W'(pair_in.first_inv_mass) + WORD_W'(pair_in.second_inv_mass);
        s1_next.hit_ok = 1'b0;
        rs_next        = WORD_W'(pair_in.first_radius) + WORD_W'(pair_in.second_radius);
    end

    // per-axis bound first keeps the squares within 64 bits
    always_comb
    begin
        ax_next = s1_reg.dx[DIFF_W-1] ? DIFF_W'(-s1_reg.dx) : DIFF_W'(s1_reg.dx);
        ay_next = s1_reg.dy[DIFF_W-1] ? DIFF_W'(-s1_reg.dy) : DIFF_W'(s1_reg.dy);
        lt_next = (ax_next < DIFF_W'(rs1_reg)) && (ay_next < DIFF_W'(rs1_reg));
    end

    always_comb
    begin
        sum_next       = (SQ_W+1)'(dx2_reg) + (SQ_W+1)'(dy2_reg);
        s4_next        = s3_reg;
        s4_next.hit_ok = lt3_reg && (sum_next < (SQ_W+1)'(rsq_reg)) && (s3_reg.msum != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg      <= s1_next;
            rs1_reg     <= rs_next;
            s2_reg      <= s1_reg;
            rs2_reg     <= rs1_reg;
            ax_reg      <= ax_next[WORD_W-1:0];
            ay_reg      <= ay_next[WORD_W-1:0];
            lt2_reg     <= lt_next;
            s3_reg      <= s2_reg;
            dx2_reg     <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            dy2_reg     <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
            rsq_reg     <= SQ_W'(rs2_reg) * SQ_W'(rs2_reg);
            lt3_reg     <= lt2_reg;
            s4_reg      <= s4_next;
            dist_sq_reg <= sum_next[SQ_W-1:0];
        end
    end

    assign valid_out = vld_reg[3];
    assign dist_sq   = dist_sq_reg;
    assign side_out  = s4_reg;

endmodule

`default_nettype wire

>>> design/cci_isqrt.sv
// ----------------------------------------------------------------------------
// cci_isqrt: pipelined integer square root
// One result bit per stage, floor of the root of a 64-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic [cci_pkg::SQ_W-1:0]    rad,
    input  cci_pkg::cci_side_t          side_in,
    output logic                        valid_out,
    output logic [cci_pkg::ROOT_W-1:0]  root,
    output cci_pkg::cci_side_t          side_out
);
    import cci_pkg::*;

    localparam int NS = ROOT_W;
    localparam int TW = SQ_W + 1;

    logic [SQ_W-1:0]   rem_src   [NS];
    logic [SQ_W-1:0]   rem_next  [NS];
    logic [SQ_W-1:0]   rem_reg   [NS];
    logic [ROOT_W-1:0] root_src  [NS];
    logic [ROOT_W-1:0] root_next [NS];
    logic [ROOT_W-1:0] root_reg  [NS];
    logic [TW-1:0]     trial     [NS];
    cci_side_t         side_reg  [NS];
    logic [NS-1:0]     vld_reg;

    always_comb
    begin
        rem_src[0]  = rad;
        root_src[0] = '0;
        for (int s = 1; s < NS; s++)
        begin
            rem_src[s]  = rem_reg[s-1];
            root_src[s] = root_reg[s-1];
        end
    end

    // stage s decides bit NS-1-s: (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            trial[s] = (TW'(root_src[s]) << (NS - s)) + (TW'(1) << (2 * (NS - 1 - s)));
            if (TW'(rem_src[s]) >= trial[s])
            begin
                rem_next[s]  = rem_src[s] - trial[s][SQ_W-1:0];
                root_next[s] = root_src[s] | (ROOT_W'(1) << (NS - 1 - s));
            end
            else
            begin
                rem_next[s]  = rem_src[s];
                root_next[s] = root_src[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 0; s < NS; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
            for (int s = 1; s < NS; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign valid_out = vld_reg[NS-1];
    assign root      = root_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

`default_nettype wire

>>> design/cci_div.sv
// ----------------------------------------------------------------------------
// cci_div: four-lane pipelined fraction divider
// Each lane computes num * 2^F / den for num <= den, one quotient bit per
// stage, then applies the sign in a final stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic [cci_pkg::DIFF_W-1:0]    num [cci_pkg::LANES],
    input  logic [cci_pkg::WORD_W-1:0]    den [cci_pkg::LANES],
    input  logic [cci_pkg::LANES-1:0]     neg,
    input  cci_pkg::cci_side_t            side_in,
    output logic                          valid_out,
    output logic signed [FRAC_BITS+1:0]   quo [cci_pkg::LANES],
    output cci_pkg::cci_side_t            side_out
);
    import cci_pkg::*;

    localparam int NS = FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 2;

    logic [DIFF_W-1:0] rem_src  [NS][LANES];
    logic [DIFF_W-1:0] rem_next [NS][LANES];
    logic [DIFF_W-1:0] rem_reg  [NS][LANES];
    logic [NS-1:0]     q_src    [NS][LANES];
    logic [NS-1:0]     q_next   [NS][LANES];
    logic [NS-1:0]     q_reg    [NS][LANES];
    logic [WORD_W-1:0] den_src  [NS][LANES];
    logic [WORD_W-1:0] den_reg  [NS][LANES];
    logic [LANES-1:0]  neg_reg  [NS];
    cci_side_t         side_reg [NS];
    logic [NS:0]       vld_reg;
    logic signed [QW-1:0] quo_next [LANES];
    logic signed [QW-1:0] quo_reg  [LANES];
    cci_side_t         side_o_reg;

    // low numerator bits are zero, so later stages shift in zeros
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_src[0][l] = num[l];
            q_src[0][l]   = '0;
            den_src[0][l] = den[l];
        end
        for (int s = 1; s < NS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_src[s][l] = {rem_reg[s-1][l][DIFF_W-2:0], 1'b0};
                q_src[s][l]   = q_reg[s-1][l];
                den_src[s][l] = den_reg[s-1][l];
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_src[s][l] >= DIFF_W'(den_src[s][l]))
                begin
                    rem_next[s][l] = rem_src[s][l] - DIFF_W'(den_src[s][l]);
                    q_next[s][l]   = {q_src[s][l][NS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][l] = rem_src[s][l];
                    q_next[s][l]   = {q_src[s][l][NS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo_next[l] = neg_reg[NS-1][l] ? -QW'(q_reg[NS-1][l]) : QW'(q_reg[NS-1][l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            neg_reg[0]  <= neg;
            for (int s = 1; s < NS; s++)
            begin
                side_reg[s] <= side_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
            end
            for (int s = 0; s < NS; s++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                    den_reg[s][l] <= den_src[s][l];
                end
            end
            for (int l = 0; l < LANES; l++)
            begin
                quo_reg[l] <= quo_next[l];
            end
            side_o_reg <= side_reg[NS-1];
        end
    end

    assign valid_out = vld_reg[NS];
    assign quo       = quo_reg;
    assign side_out  = side_o_reg;

endmodule

`default_nettype wire

>>> design/cci_resp.sv
// ----------------------------------------------------------------------------
// cci_resp: closing speed, impulse and velocity update
// Seven stages: normal projections, their sum, approach test, impulse
// scale per body, impulse along the normal, rounding, update and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_resp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic signed [FRAC_BITS+1:0]   quo [cci_pkg::LANES],
    input  cci_pkg::cci_side_t            side_in,
    output logic                          valid_out,
    output cci_pkg::cci_result_t          result_out
);
    import cci_pkg::*;

    localparam int QW  = FRAC_BITS + 2;
    localparam int FW  = FRAC_BITS + 1;
    localparam int PW  = DIFF_W + QW;
    localparam int SW  = PW + 1;
    localparam int MW  = SW - FRAC_BITS;
    localparam int KPW = MW + FW;
    localparam int KNW = MW + 1 + QW;
    localparam int DW  = KNW - FRAC_BITS;
    localparam int NW  = DW + 1;
    localparam logic signed [KNW-1:0] BIAS = KNW'((1 << FRAC_BITS) - 1);

    cci_side_t            sd_reg [6];
    logic [6:0]           vld_reg;
    logic signed [QW-1:0] q_reg  [4][LANES];
    logic signed [PW-1:0] px_reg, py_reg;
    logic signed [SW-1:0] sum_reg, neg_sum;
    logic [MW-1:0]        mag2_next, mag2_reg;
    logic                 apply_next;
    logic [3:0]           app_reg;
    logic [KPW-1:0]       kp1, kp2;
    logic [MW-1:0]        k1_reg, k2_reg;
    logic signed [KNW-1:0] kn_next [4];
    logic signed [KNW-1:0] kn_reg  [4];
    logic signed [KNW-1:0] kn_adj  [4];
    logic signed [DW-1:0]  d_next  [4];
    logic signed [DW-1:0]  d_reg   [4];
    cci_result_t          res_next, res_reg;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [NW-1:0] x);
        priority if (x > NW'(WORD_MAX))
            sat_word = WORD_MAX;
        else if (x < NW'(WORD_MIN))
            sat_word = WORD_MIN;
        else
            sat_word = x[WORD_W-1:0];
    endfunction

    // closing speed is negative only when -sum >= 2^F (truncation toward zero)
    always_comb
    begin
        neg_sum    = -sum_reg;
        apply_next = sd_reg[1].hit_ok && sum_reg[SW-1] && (neg_sum[SW-1:FRAC_BITS] != '0);
        mag2_next  = MW'({neg_sum[SW-1:FRAC_BITS], 1'b0});
    end

    always_comb
    begin
        kp1 = KPW'(mag2_reg) * KPW'(q_reg[2][LANE_F1][FW-1:0]);
        kp2 = KPW'(mag2_reg) * KPW'(q_reg[2][LANE_F2][FW-1:0]);
    end

    always_comb
    begin
        kn_next[0] = KNW'($signed({1'b0, k1_reg})) * KNW'(q_reg[3][LANE_NX]);
        kn_next[1] = KNW'($signed({1'b0, k1_reg})) * KNW'(q_reg[3][LANE_NY]);
        kn_next[2] = KNW'($signed({1'b0, k2_reg})) * KNW'(q_reg[3][LANE_NX]);
        kn_next[3] = KNW'($signed({1'b0, k2_reg})) * KNW'(q_reg[3][LANE_NY]);
        for (int i = 0; i < 4; i++)
        begin
            kn_adj[i] = kn_reg[i] + (kn_reg[i][KNW-1] ? BIAS : KNW'(0));
            d_next[i] = DW'(kn_adj[i] >>> FRAC_BITS);
        end
    end

    always_comb
    begin
        res_next.impulse_applied = app_reg[3];
        if (app_reg[3])
        begin
            res_next.new_first_vel_x  = sat_word(NW'(sd_reg[5].v1x) - NW'(d_reg[0]));
            res_next.new_first_vel_y  = sat_word(NW'(sd_reg[5].v1y) - NW'(d_reg[1]));
            res_next.new_second_vel_x = sat_word(NW'(sd_reg[5].v2x) + NW'(d_reg[2]));
            res_next.new_second_vel_y = sat_word(NW'(sd_reg[5].v2y) + NW'(d_reg[3]));
        end
        else
        begin
            res_next.new_first_vel_x  = sd_reg[5].v1x;
            res_next.new_first_vel_y  = sd_reg[5].v1y;
            res_next.new_second_vel_x = sd_reg[5].v2x;
            res_next.new_second_vel_y = sd_reg[5].v2y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= side_in;
            for (int s = 1; s < 6; s++)
            begin
                sd_reg[s] <= sd_reg[s-1];
            end
            for (int l = 0; l < LANES; l++)
            begin
                q_reg[0][l] <= quo[l];
                q_reg[1][l] <= q_reg[0][l];
                q_reg[2][l] <= q_reg[1][l];
                q_reg[3][l] <= q_reg[2][l];
            end
            px_reg   <= PW'(side_in.rvx) * PW'(quo[LANE_NX]);
            py_reg   <= PW'(side_in.rvy) * PW'(quo[LANE_NY]);
            sum_reg  <= SW'(px_reg) + SW'(py_reg);
            mag2_reg <= mag2_next;
            app_reg  <= {app_reg[2:0], apply_next};
            k1_reg   <= kp1[MW+FRAC_BITS-1:FRAC_BITS];
            k2_reg   <= kp2[MW+FRAC_BITS-1:FRAC_BITS];
            for (int i = 0; i < 4; i++)
            begin
                kn_reg[i] <= kn_next[i];
                d_reg[i]  <= d_next[i];
            end
            res_reg <= res_next;
        end
    end

    assign valid_out  = vld_reg[6];
    assign result_out = res_reg;

endmodule

`default_nettype wire

>>> design/circle_collision_impulse_unit.sv
// ----------------------------------------------------------------------------
// circle_collision_impulse_unit: elastic impulse response for circle pairs
// A request carries two bodies (position, velocity, radius, inverse mass,
// all Q fixed point). A result carries both updated velocities and a flag
// set when an impulse was applied (overlapping and approaching bodies).
// Both channels use valid/stall; a request is taken when valid is high and
// stall is low. One request per cycle is accepted while pair_stall is low.
// Pipeline from acceptance to result valid: 4 overlap stages, 32 square-root
// stages (one root bit each), FRACTION_BITS + 2 divider stages (one quotient
// bit each but the last, which applies the sign; FRACTION_BITS is 16 at
// Q16.16), 7 impulse stages and the output register.
// When the receiver stalls, the output register holds its result and a skid
// register takes the next one out of the pipeline; only when the skid is
// full does the pipeline freeze and pair_stall rise.
// Reset clears all valid bits, so no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_collision_impulse_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pair_valid,
    output logic                  pair_stall,
    input  cci_pkg::cci_pair_t    pair,
    output logic                  result_valid,
    input  logic                  result_stall,
    output cci_pkg::cci_result_t  result
);
    import cci_pkg::*;

    localparam int QW = FRACTION_BITS + 2;

    logic                 en;
    logic                 prep_valid, sq_valid, div_valid, pipe_valid;
    logic [SQ_W-1:0]      dist_sq;
    cci_side_t            prep_side, sq_side, div_side_in, div_side;
    logic [ROOT_W-1:0]    center_dist;
    logic [DIFF_W-1:0]    div_num [LANES];
    logic [WORD_W-1:0]    div_den [LANES];
    logic [LANES-1:0]     div_neg;
    logic signed [QW-1:0] div_quo [LANES];
    cci_result_t          pipe_result, result_reg, skid_reg;
    logic                 result_valid_reg, skid_valid_reg;
    logic                 take_free;

    assign en = !skid_valid_reg;

    cci_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pair_valid),
        .pair_in   (pair),
        .valid_out (prep_valid),
        .dist_sq   (dist_sq),
        .side_out  (prep_side)
    );

    cci_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (prep_valid),
        .rad       (dist_sq),
        .side_in   (prep_side),
        .valid_out (sq_valid),
        .root      (center_dist),
        .side_out  (sq_side)
    );

    // lanes: normal x, normal y, mass fraction of each body
    always_comb
    begin
        div_side_in        = sq_side;
        div_side_in.hit_ok = sq_side.hit_ok && (center_dist != '0);
        div_num[LANE_NX] = sq_side.dx[DIFF_W-1] ? DIFF_W'(-sq_side.dx) : DIFF_W'(sq_side.dx);
        div_num[LANE_NY] = sq_side.dy[DIFF_W-1] ? DIFF_W'(-sq_side.dy) : DIFF_W'(sq_side.dy);
        div_num[LANE_F1] = DIFF_W'(sq_side.m1);
        div_num[LANE_F2] = DIFF_W'(sq_side.m2);
        div_den[LANE_NX] = center_dist;
        div_den[LANE_NY] = center_dist;
        div_den[LANE_F1] = sq_side.msum;
        div_den[LANE_F2] = sq_side.msum;
        div_neg = '0;
        div_neg[LANE_NX] = sq_side.dx[DIFF_W-1];
        div_neg[LANE_NY] = sq_side.dy[DIFF_W-1];
    end

    cci_div #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (sq_valid),
        .num       (div_num),
        .den       (div_den),
        .neg       (div_neg),
        .side_in   (div_side_in),
        .valid_out (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    cci_resp #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_resp (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid_in   (div_valid),
        .quo        (div_quo),
        .side_in    (div_side),
        .valid_out  (pipe_valid),
        .result_out (pipe_result)
    );

    assign take_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take_free)
            begin
                result_valid_reg <= 1'b1;
                skid_valid_reg   <= 1'b0;
            end
        end
        else if (take_free)
        begin
            result_valid_reg <= pipe_valid;
        end
        else if (pipe_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take_free)
            begin
                result_reg <= skid_reg;
            end
        end
        else if (take_free)
        begin
            result_reg <= pipe_result;
        end
        else if (pipe_valid)
        begin
            skid_reg <= pipe_result;
        end
    end

    assign pair_stall   = skid_valid_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_skid_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid register full while output register is empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result_valid_reg && result_stall))
        else $error("skid register filled without a stalled output");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_valid && !skid_valid_reg && result_valid_reg && result_stall) |=> skid_valid_reg)
        else $error("pipeline result dropped while output stalled");

endmodule

`default_nettype wire
